[src/acdc_pkg.sv]
// ----------------------------------------------------------------------------
// Audio clock drift compensator package
// Shared constants, types and frequency-adjust arithmetic.
// ----------------------------------------------------------------------------
package acdc_pkg;

  localparam int BLOCK_PERIOD_US_DEF   = 1000;
  localparam int MEASURE_PERIOD_US_DEF = 100000;
  localparam int WAIT_STEPS_DEF        = 100;

  localparam int TIME_W     = 32;
  localparam int CODE_W     = 16;
  localparam int THR_W      = 8;
  localparam int CNT_W      = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int CMP_W      = 16;

  localparam logic [CNT_W-1:0] CNT_MAX = 7'd127;

  // adjust = -(err * 1000) / 331, magnitude through a reciprocal multiply
  localparam int ADJ_IN_W      = 15;
  localparam int ADJ_MAG_W     = 17;
  localparam int ADJ_W         = 18;
  localparam int SUM_W         = 19;
  localparam int FREQ_GAIN_NUM = 1000;
  localparam int FREQ_GAIN_DEN = 331;
  localparam int ADJ_SHIFT     = 34;
  localparam int ADJ_RECIP_W   = 36;
  localparam int ADJ_PROD_W    = ADJ_SHIFT + ADJ_MAG_W;
  localparam logic [ADJ_RECIP_W-1:0] ADJ_RECIP = 36'(64'(FREQ_GAIN_NUM) *
      (((64'd1 << ADJ_SHIFT) + 64'(FREQ_GAIN_DEN) - 64'd1) / 64'(FREQ_GAIN_DEN)));

  localparam logic [THR_W-1:0]  LOCK_THR_RST   = 8'd16;
  localparam logic [THR_W-1:0]  UNLOCK_THR_RST = 8'd32;
  localparam logic [CODE_W-1:0] NOMINAL_RST    = 16'd39854;
  localparam logic [CODE_W-1:0] MIN_CODE_RST   = 16'd36834;
  localparam logic [CODE_W-1:0] MAX_CODE_RST   = 16'd42874;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOCK_THR   = 3'd0,
    REG_UNLOCK_THR = 3'd1,
    REG_NOMINAL    = 3'd2,
    REG_MIN_CODE   = 3'd3,
    REG_MAX_CODE   = 3'd4
  } acdc_reg_t;

  typedef enum logic [1:0] {
    MODE_INIT   = 2'd0,
    MODE_CALIB  = 2'd1,
    MODE_OFFSET = 2'd2,
    MODE_LOCKED = 2'd3
  } acdc_mode_t;

  typedef struct packed {
    logic [THR_W-1:0]  lock_thr;
    logic [THR_W-1:0]  unlock_thr;
    logic [CODE_W-1:0] nominal_code;
    logic [CODE_W-1:0] min_code;
    logic [CODE_W-1:0] max_code;
  } acdc_cfg_t;

  function automatic logic [ADJ_MAG_W-1:0] adj_mag(input logic [ADJ_IN_W-1:0] mag);
    logic [ADJ_PROD_W-1:0] prod;
    prod = ADJ_PROD_W'(mag) * ADJ_PROD_W'(ADJ_RECIP);
    return prod[ADJ_PROD_W-1 -: ADJ_MAG_W];
  endfunction

  // negative error raises the code, positive error lowers it
  function automatic logic signed [ADJ_W-1:0] adj_signed(input logic [ADJ_IN_W-1:0] mag,
                                                         input logic neg);
    logic signed [ADJ_W-1:0] qs;
    qs = $signed({1'b0, adj_mag(mag)});
    return neg ? qs : -qs;
  endfunction

endpackage

[src/audio_clock_drift_compensator_unit.sv]
// ----------------------------------------------------------------------------
// Audio clock drift compensator
// Path: the accepting edge loads the first of three phase pipeline stages, which feed
// the trim loop result register.
// Throughput: one request per cycle while results drain; loop state steps per request.
// Reset: synchronous; clears pipeline, loop state to init and loads default
// configuration. Ready from the cycle after reset.
// ----------------------------------------------------------------------------
module audio_clock_drift_compensator_unit #(
  parameter int BLOCK_PERIOD_US   = acdc_pkg::BLOCK_PERIOD_US_DEF,
  parameter int MEASURE_PERIOD_US = acdc_pkg::MEASURE_PERIOD_US_DEF,
  parameter int WAIT_STEPS        = acdc_pkg::WAIT_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [acdc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [acdc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [acdc_pkg::TIME_W-1:0]       frame_start_us,
  input  logic [acdc_pkg::TIME_W-1:0]       last_ref_us,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              freq_write,
  output logic [acdc_pkg::CODE_W-1:0]       freq_code,
  output logic [1:0]                        loop_mode
);

  localparam int PMW = $clog2(BLOCK_PERIOD_US / 2 + 1);

  acdc_pkg::acdc_cfg_t                cfg;
  logic                               ph_valid, ph_ready;
  logic [acdc_pkg::TIME_W-1:0]        ph_ref, ph_base;
  logic signed [acdc_pkg::ADJ_W-1:0]  ph_adj_off, ph_adj_lock;
  logic [PMW-1:0]                     ph_mag;

  acdc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  acdc_phase #(
    .BLOCK_PERIOD_US   (BLOCK_PERIOD_US),
    .MEASURE_PERIOD_US (MEASURE_PERIOD_US)
  ) u_phase (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .frame_start_us (frame_start_us),
    .last_ref_us    (last_ref_us),
    .out_valid      (ph_valid),
    .out_ready      (ph_ready),
    .ref_us         (ph_ref),
    .cal_base       (ph_base),
    .adj_off        (ph_adj_off),
    .adj_lock       (ph_adj_lock),
    .phase_mag      (ph_mag)
  );

  acdc_loop #(
    .BLOCK_PERIOD_US (BLOCK_PERIOD_US),
    .WAIT_STEPS      (WAIT_STEPS)
  ) u_loop (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (ph_valid),
    .in_ready   (ph_ready),
    .ref_us     (ph_ref),
    .cal_base   (ph_base),
    .adj_off    (ph_adj_off),
    .adj_lock   (ph_adj_lock),
    .phase_mag  (ph_mag),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .freq_write (freq_write),
    .freq_code  (freq_code),
    .loop_mode  (loop_mode)
  );

endmodule

[src/acdc_cfg.sv]
// ----------------------------------------------------------------------------
// Configuration registers
// Holds thresholds and frequency code limits written over the config channel.
// ----------------------------------------------------------------------------
module acdc_cfg (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [acdc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [acdc_pkg::CFG_DATA_W-1:0]      cfg_data,
  output acdc_pkg::acdc_cfg_t                  cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lock_thr     <= acdc_pkg::LOCK_THR_RST;
      cfg.unlock_thr   <= acdc_pkg::UNLOCK_THR_RST;
      cfg.nominal_code <= acdc_pkg::NOMINAL_RST;
      cfg.min_code     <= acdc_pkg::MIN_CODE_RST;
      cfg.max_code     <= acdc_pkg::MAX_CODE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        acdc_pkg::REG_LOCK_THR:   cfg.lock_thr     <= cfg_data[acdc_pkg::THR_W-1:0];
        acdc_pkg::REG_UNLOCK_THR: cfg.unlock_thr   <= cfg_data[acdc_pkg::THR_W-1:0];
        acdc_pkg::REG_NOMINAL:    cfg.nominal_code <= cfg_data[acdc_pkg::CODE_W-1:0];
        acdc_pkg::REG_MIN_CODE:   cfg.min_code     <= cfg_data[acdc_pkg::CODE_W-1:0];
        acdc_pkg::REG_MAX_CODE:   cfg.max_code     <= cfg_data[acdc_pkg::CODE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

[src/acdc_phase.sv]
// ----------------------------------------------------------------------------
// Phase error front end
// Three-stage pipeline: block-period reciprocal divide, remainder and wrap,
// then offset and locked frequency adjustments from the phase error.
// ----------------------------------------------------------------------------
module acdc_phase #(
  parameter int BLOCK_PERIOD_US   = acdc_pkg::BLOCK_PERIOD_US_DEF,
  parameter int MEASURE_PERIOD_US = acdc_pkg::MEASURE_PERIOD_US_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic [acdc_pkg::TIME_W-1:0]              frame_start_us,
  input  logic [acdc_pkg::TIME_W-1:0]              last_ref_us,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic [acdc_pkg::TIME_W-1:0]              ref_us,
  output logic [acdc_pkg::TIME_W-1:0]              cal_base,
  output logic signed [acdc_pkg::ADJ_W-1:0]        adj_off,
  output logic signed [acdc_pkg::ADJ_W-1:0]        adj_lock,
  output logic [$clog2(BLOCK_PERIOD_US / 2 + 1)-1:0] phase_mag
);

  localparam int PER_L = $clog2(BLOCK_PERIOD_US);
  localparam int QW    = 33 - PER_L;
  localparam int PMW   = $clog2(BLOCK_PERIOD_US / 2 + 1);
  localparam logic [32:0] RECIP = 33'(((64'd1 << (32 + PER_L)) +
      64'(BLOCK_PERIOD_US) - 64'd1) / 64'(BLOCK_PERIOD_US));
  localparam logic [31:0] PERIOD = 32'(BLOCK_PERIOD_US);
  localparam logic [31:0] HALF   = 32'(BLOCK_PERIOD_US / 2);
  localparam logic [31:0] MEAS   = 32'(MEASURE_PERIOD_US);

  logic        s1_valid, s2_valid, s3_valid;
  logic        rdy1, rdy2, rdy3;

  logic [31:0] diff;
  logic [64:0] quot_prod;
  logic [31:0] s1_diff;
  logic [QW-1:0] s1_quot;
  logic [31:0] s1_ref, s1_base;

  logic [31:0] rem0, rem, mag32;
  logic        neg;
  logic [PMW-1:0] s2_mag;
  logic        s2_neg;
  logic [31:0] s2_ref, s2_base;

  logic signed [acdc_pkg::ADJ_W-1:0] off_val, lock_val;
  logic [PMW-1:0] half_mag;

  assign rdy3     = !s3_valid || out_ready;
  assign rdy2     = !s2_valid || rdy3;
  assign rdy1     = !s1_valid || rdy2;
  assign in_ready = rdy1;
  assign out_valid = s3_valid;

  assign diff      = last_ref_us - frame_start_us;
  assign quot_prod = 65'(diff) * 65'(RECIP);

  always_comb begin
    rem0  = s1_diff - 32'(s1_quot) * PERIOD;
    rem   = (rem0 >= PERIOD) ? rem0 - PERIOD : rem0;
    neg   = rem > HALF;
    mag32 = neg ? PERIOD - rem : rem;
  end

  assign half_mag = s2_mag >> 1;
  assign off_val  = acdc_pkg::adj_signed(acdc_pkg::ADJ_IN_W'(s2_mag), s2_neg);
  assign lock_val = acdc_pkg::adj_signed(acdc_pkg::ADJ_IN_W'(half_mag), s2_neg);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (rdy1) s1_valid <= in_valid;
      if (rdy2) s2_valid <= s1_valid;
      if (rdy3) s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      s1_diff <= diff;
      s1_quot <= quot_prod[64 -: QW];
      s1_ref  <= last_ref_us;
      s1_base <= MEAS - last_ref_us;
    end
    if (rdy2 && s1_valid) begin
      s2_mag  <= mag32[PMW-1:0];
      s2_neg  <= neg;
      s2_ref  <= s1_ref;
      s2_base <= s1_base;
    end
    if (rdy3 && s2_valid) begin
      adj_off   <= off_val;
      adj_lock  <= lock_val;
      phase_mag <= s2_mag;
      ref_us    <= s2_ref;
      cal_base  <= s2_base;
    end
  end

endmodule

[src/acdc_loop.sv]
// ----------------------------------------------------------------------------
// Trim loop
// Init, calibrate, offset and locked mode sequencer with wait counter,
// calibrated centre code and the result register.
// ----------------------------------------------------------------------------
module acdc_loop #(
  parameter int BLOCK_PERIOD_US = acdc_pkg::BLOCK_PERIOD_US_DEF,
  parameter int WAIT_STEPS      = acdc_pkg::WAIT_STEPS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  acdc_pkg::acdc_cfg_t                        cfg,
  input  logic                                       in_valid,
  output logic                                       in_ready,
  input  logic [acdc_pkg::TIME_W-1:0]                ref_us,
  input  logic [acdc_pkg::TIME_W-1:0]                cal_base,
  input  logic signed [acdc_pkg::ADJ_W-1:0]          adj_off,
  input  logic signed [acdc_pkg::ADJ_W-1:0]          adj_lock,
  input  logic [$clog2(BLOCK_PERIOD_US / 2 + 1)-1:0] phase_mag,
  output logic                                       out_valid,
  input  logic                                       out_ready,
  output logic                                       freq_write,
  output logic [acdc_pkg::CODE_W-1:0]                freq_code,
  output logic [1:0]                                 loop_mode
);

  localparam int SUM_W  = acdc_pkg::SUM_W;
  localparam int CODE_W = acdc_pkg::CODE_W;
  localparam int CNT_W  = acdc_pkg::CNT_W;
  localparam int CMP_W  = acdc_pkg::CMP_W;
  localparam logic [CNT_W-1:0] WAIT_LIM = CNT_W'(WAIT_STEPS);

  acdc_pkg::acdc_mode_t mode, mode_next;
  logic [CNT_W-1:0]     wait_counter, wait_counter_next, cnt_inc;
  logic [31:0]          measure_start_us, measure_start_us_next;
  logic [CODE_W-1:0]    centre_code, centre_code_next;
  logic                 write_next;
  logic [CODE_W-1:0]    code_next;

  logic                 take, waiting;
  logic [31:0]          cal_err, cal_abs;
  logic                 cal_neg, cal_big, cal_ok;
  logic signed [acdc_pkg::ADJ_W-1:0] cal_adj, sel_adj;
  logic signed [SUM_W-1:0] cal_code, trim_sum;
  logic [CODE_W-1:0]    trim_code;
  logic                 lock_hit, unlock_hit;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  always_comb begin
    cnt_inc = (wait_counter < acdc_pkg::CNT_MAX) ? wait_counter + 7'd1 : wait_counter;
    waiting = cnt_inc < WAIT_LIM;

    cal_err  = cal_base + measure_start_us;
    cal_neg  = cal_err[31];
    cal_abs  = cal_neg ? (~cal_err + 32'd1) : cal_err;
    cal_big  = |cal_abs[31:acdc_pkg::ADJ_IN_W];
    cal_adj  = acdc_pkg::adj_signed(cal_abs[acdc_pkg::ADJ_IN_W-1:0], cal_neg);
    cal_code = $signed({3'b000, cfg.nominal_code}) + SUM_W'(cal_adj);
    cal_ok   = !cal_big && (cal_code >= $signed({3'b000, cfg.min_code}))
               && (cal_code <= $signed({3'b000, cfg.max_code}));

    sel_adj  = (mode == acdc_pkg::MODE_LOCKED) ? adj_lock : adj_off;
    trim_sum = $signed({3'b000, centre_code}) + SUM_W'(sel_adj);
    if (trim_sum[SUM_W-1]) begin
      trim_code = '0;
    end else if (|trim_sum[SUM_W-2:CODE_W]) begin
      trim_code = '1;
    end else begin
      trim_code = trim_sum[CODE_W-1:0];
    end

    lock_hit   = CMP_W'(phase_mag) < CMP_W'(cfg.lock_thr);
    unlock_hit = CMP_W'(phase_mag >> 1) > CMP_W'(cfg.unlock_thr);
  end

  always_comb begin
    mode_next             = mode;
    wait_counter_next     = wait_counter;
    measure_start_us_next = measure_start_us;
    centre_code_next      = centre_code;
    write_next            = 1'b0;
    code_next             = '0;
    if (take) begin
      case (mode)
        acdc_pkg::MODE_INIT: begin
          if (ref_us != '0) begin
            measure_start_us_next = ref_us;
            mode_next             = acdc_pkg::MODE_CALIB;
            wait_counter_next     = '0;
          end
        end
        acdc_pkg::MODE_CALIB: begin
          wait_counter_next = cnt_inc;
          if (!waiting) begin
            if (cal_ok) begin
              centre_code_next = cal_code[CODE_W-1:0];
              write_next       = 1'b1;
              code_next        = cal_code[CODE_W-1:0];
              mode_next        = acdc_pkg::MODE_OFFSET;
            end else begin
              mode_next = acdc_pkg::MODE_INIT;
            end
            wait_counter_next = '0;
          end
        end
        acdc_pkg::MODE_OFFSET: begin
          wait_counter_next = cnt_inc;
          if (!waiting) begin
            write_next = 1'b1;
            code_next  = trim_code;
            if (lock_hit) begin
              mode_next         = acdc_pkg::MODE_LOCKED;
              wait_counter_next = '0;
            end
          end
        end
        default: begin
          wait_counter_next = cnt_inc;
          if (!waiting) begin
            write_next        = 1'b1;
            code_next         = trim_code;
            wait_counter_next = '0;
            if (unlock_hit) mode_next = acdc_pkg::MODE_INIT;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= acdc_pkg::MODE_INIT;
      wait_counter     <= '0;
      measure_start_us <= '0;
      centre_code      <= '0;
    end else begin
      mode             <= mode_next;
      wait_counter     <= wait_counter_next;
      measure_start_us <= measure_start_us_next;
      centre_code      <= centre_code_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      freq_write <= write_next;
      freq_code  <= code_next;
      loop_mode  <= mode_next;
    end
  end

endmodule

[src/acdc_checker.sv]
// ----------------------------------------------------------------------------
// Port checker
// Result channel properties of the drift compensator, bound to the top level.
// ----------------------------------------------------------------------------
module acdc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        freq_write,
  input logic [acdc_pkg::CODE_W-1:0] freq_code,
  input logic [1:0]                  loop_mode
);

  a_idle_after_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid straight after reset");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(freq_write)
                                && $stable(freq_code) && $stable(loop_mode))
    else $error("stalled result changed");

  a_code_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !freq_write |-> freq_code == '0)
    else $error("code without write");

  a_calib_silent: assert property (@(posedge clk) disable iff (rst)
    out_valid && loop_mode == acdc_pkg::MODE_CALIB |-> !freq_write)
    else $error("code issued while calibrating");

endmodule

bind audio_clock_drift_compensator_unit acdc_checker u_acdc_checker (.*);

[sim/acdc_trim_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Audio clock drift compensator checker
// Watches the register, request and result channels, predicts the trim loop
// code and mode for every accepted request and compares each result in order.
// ----------------------------------------------------------------------------
module acdc_trim_checker
  import acdc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [TIME_W-1:0]     frame_start_us,
  input  logic [TIME_W-1:0]     last_ref_us,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  freq_write,
  input  logic [CODE_W-1:0]     freq_code,
  input  logic [1:0]            loop_mode,
  output int                    results_due,
  output int                    mismatches
);

  typedef struct packed {
    logic              write;
    logic [CODE_W-1:0] code;
    acdc_mode_t        mode;
  } trim_result_t;

  acdc_cfg_t        trim_cfg;
  acdc_mode_t       loop_state;
  logic [CNT_W-1:0] wait_cnt;
  logic [TIME_W-1:0] measure_start;
  logic [CODE_W-1:0] centre;
  trim_result_t     trim_results_q[$];

  function automatic longint code_adjust(input longint err);
    return -(err * FREQ_GAIN_NUM) / FREQ_GAIN_DEN;
  endfunction

  function automatic longint block_phase(input logic [TIME_W-1:0] frame,
                                         input logic [TIME_W-1:0] ref_us);
    logic [TIME_W-1:0] rem;
    longint err;
    rem = (ref_us - frame) % TIME_W'(BLOCK_PERIOD_US_DEF);
    err = rem;
    if (err > BLOCK_PERIOD_US_DEF / 2) err -= BLOCK_PERIOD_US_DEF;
    return err;
  endfunction

  function automatic logic [CODE_W-1:0] clamp_code(input longint v);
    if (v < 0) return '0;
    if (v > 65535) return '1;
    return CODE_W'(v);
  endfunction

  function automatic bit settling();
    if (wait_cnt < CNT_MAX) wait_cnt++;
    return wait_cnt < CNT_W'(WAIT_STEPS_DEF);
  endfunction

  function automatic void enter_mode(input acdc_mode_t m);
    if (m != loop_state) begin
      wait_cnt   = '0;
      loop_state = m;
    end
  endfunction

  function automatic trim_result_t step_trim_loop(input logic [TIME_W-1:0] frame,
                                                  input logic [TIME_W-1:0] ref_us);
    trim_result_t res;
    logic signed [TIME_W-1:0] moved;
    logic [TIME_W-1:0] err_lo;
    longint err;
    longint centre_next;
    res.write = 1'b0;
    res.code  = '0;
    case (loop_state)
      MODE_INIT: begin
        if (ref_us != '0) begin
          measure_start = ref_us;
          enter_mode(MODE_CALIB);
        end
      end
      MODE_CALIB: begin
        if (!settling()) begin
          moved       = $signed(ref_us - measure_start);
          err         = longint'(MEASURE_PERIOD_US_DEF) - longint'(moved);
          err_lo      = err[TIME_W-1:0];
          err         = longint'($signed(err_lo));
          centre_next = longint'(trim_cfg.nominal_code) + code_adjust(err);
          if (centre_next > longint'(trim_cfg.max_code) ||
              centre_next < longint'(trim_cfg.min_code)) begin
            enter_mode(MODE_INIT);
          end else begin
            centre    = centre_next[CODE_W-1:0];
            res.write = 1'b1;
            res.code  = centre;
            enter_mode(MODE_OFFSET);
          end
        end
      end
      MODE_OFFSET: begin
        if (!settling()) begin
          err       = block_phase(frame, ref_us);
          res.write = 1'b1;
          res.code  = clamp_code(longint'(centre) + code_adjust(err));
          if (err < longint'(trim_cfg.lock_thr) && err > -longint'(trim_cfg.lock_thr))
            enter_mode(MODE_LOCKED);
        end
      end
      default: begin
        if (!settling()) begin
          err       = block_phase(frame, ref_us) / 2;
          res.write = 1'b1;
          res.code  = clamp_code(longint'(centre) + code_adjust(err));
          if (err > longint'(trim_cfg.unlock_thr) || err < -longint'(trim_cfg.unlock_thr))
            enter_mode(MODE_INIT);
          else
            wait_cnt = '0;
        end
      end
    endcase
    res.mode = loop_state;
    return res;
  endfunction

  always @(posedge clk) begin : watch
    trim_result_t want;
    if (rst) begin
      trim_cfg.lock_thr     = LOCK_THR_RST;
      trim_cfg.unlock_thr   = UNLOCK_THR_RST;
      trim_cfg.nominal_code = NOMINAL_RST;
      trim_cfg.min_code     = MIN_CODE_RST;
      trim_cfg.max_code     = MAX_CODE_RST;
      loop_state    = MODE_INIT;
      wait_cnt      = '0;
      measure_start = '0;
      centre        = '0;
      trim_results_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (acdc_reg_t'(cfg_index))
          REG_LOCK_THR:   trim_cfg.lock_thr     = cfg_data[THR_W-1:0];
          REG_UNLOCK_THR: trim_cfg.unlock_thr   = cfg_data[THR_W-1:0];
          REG_NOMINAL:    trim_cfg.nominal_code = cfg_data[CODE_W-1:0];
          REG_MIN_CODE:   trim_cfg.min_code     = cfg_data[CODE_W-1:0];
          REG_MAX_CODE:   trim_cfg.max_code     = cfg_data[CODE_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (trim_results_q.size() == 0) begin
          mismatches++;
          $display("%0t unexpected result: expected none, actual write %0b code %0d mode %0d",
                   $time, freq_write, freq_code, loop_mode);
        end else begin
          want = trim_results_q.pop_front();
          if (freq_write !== want.write) begin
            mismatches++;
            $display("%0t freq_write: expected %0b actual %0b", $time, want.write, freq_write);
          end
          if (freq_code !== want.code) begin
            mismatches++;
            $display("%0t freq_code: expected %0d actual %0d", $time, want.code, freq_code);
          end
          if (loop_mode !== want.mode) begin
            mismatches++;
            $display("%0t loop_mode: expected %0d actual %0d", $time, want.mode, loop_mode);
          end
        end
      end
      if (in_valid && in_ready)
        trim_results_q.push_back(step_trim_loop(frame_start_us, last_ref_us));
    end
    results_due = trim_results_q.size();
  end

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Audio clock drift compensator testbench
// Drives timestamp requests shaped like steady audio blocks with drift, noise
// and restarts, reprogrammes the loop registers between phases and leaves
// prediction and comparison to the checker.
// ----------------------------------------------------------------------------
module testbench;
  import acdc_pkg::*;

  localparam int RANDOM_ITEMS    = 1150;
  localparam int MAX_GAP         = 14;
  localparam int PRESSURE_CYCLES = 150;
  localparam int STALL_LIMIT     = 5000;
  localparam int DRAIN_CYCLES    = 20;
  localparam int PROBE_COUNT     = 10;

  localparam logic [TIME_W-1:0] PROBE_FRAME [PROBE_COUNT] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
    32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0001, 32'h0000_0000, 32'h7FFF_FFFF};
  localparam logic [TIME_W-1:0] PROBE_REF [PROBE_COUNT] = '{
    32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000,
    32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000};

  typedef enum int {
    SET_DEFAULT,
    SET_WIDE_LOCK,
    SET_NO_LOCK,
    SET_LOW_CENTRE,
    SET_HIGH_CENTRE,
    SET_INVERTED_LIMITS,
    SET_RANDOM
  } trim_setting_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [TIME_W-1:0]     frame_start_us;
  logic [TIME_W-1:0]     last_ref_us;
  logic                  out_valid;
  logic                  out_ready;
  logic                  freq_write;
  logic [CODE_W-1:0]     freq_code;
  logic [1:0]            loop_mode;
  int                    results_due;
  int                    mismatches;

  bit                sender_eager;
  int                idle_cycles = 0;
  logic [TIME_W-1:0] stream_frame;
  logic [TIME_W-1:0] ref_offset;
  int                drift;
  int                zero_refs;

  audio_clock_drift_compensator_unit dut (.*);

  acdc_trim_checker trim_check (.*);

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("audio_clock_drift_compensator_unit: mismatch");
      $finish;
    end
  end

  task automatic send_request(input logic [TIME_W-1:0] frame, input logic [TIME_W-1:0] ref_us);
    int gap;
    gap = sender_eager ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    frame_start_us <= frame;
    last_ref_us    <= ref_us;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    int gap;
    gap = $urandom_range(0, MAX_GAP);
    @(negedge clk);
    if (gap > 0) begin
      cfg_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_trim_setting(input trim_setting_t which);
    logic [THR_W-1:0]  lock_t;
    logic [THR_W-1:0]  unlock_t;
    logic [CODE_W-1:0] nom;
    logic [CODE_W-1:0] lo;
    logic [CODE_W-1:0] hi;
    int                lo_i;
    int                hi_i;
    lock_t   = LOCK_THR_RST;
    unlock_t = UNLOCK_THR_RST;
    nom      = NOMINAL_RST;
    lo       = MIN_CODE_RST;
    hi       = MAX_CODE_RST;
    case (which)
      SET_WIDE_LOCK: begin
        lock_t   = '1;
        unlock_t = '1;
      end
      SET_NO_LOCK: begin
        lock_t   = '0;
        unlock_t = '0;
      end
      SET_LOW_CENTRE: begin
        nom      = '0;
        lo       = '0;
        hi       = '1;
        lock_t   = THR_W'($urandom());
        unlock_t = THR_W'($urandom());
      end
      SET_HIGH_CENTRE: begin
        nom = '1;
        lo  = '0;
        hi  = '1;
      end
      SET_INVERTED_LIMITS: begin
        lo = '1;
        hi = '0;
      end
      SET_RANDOM: begin
        lock_t   = THR_W'($urandom_range(0, 64));
        unlock_t = THR_W'($urandom());
        nom      = CODE_W'($urandom());
        lo_i     = int'(nom) - int'($urandom_range(0, 4000));
        hi_i     = int'(nom) + int'($urandom_range(0, 4000));
        if (lo_i < 0) lo_i = 0;
        if (hi_i > 65535) hi_i = 65535;
        lo = CODE_W'(lo_i);
        hi = CODE_W'(hi_i);
      end
      default: ;
    endcase
    write_reg(REG_LOCK_THR, {8'($urandom()), lock_t});
    write_reg(REG_UNLOCK_THR, {8'($urandom()), unlock_t});
    write_reg(REG_NOMINAL, nom);
    write_reg(REG_MIN_CODE, lo);
    write_reg(REG_MAX_CODE, hi);
    if ($urandom_range(0, 2) == 0)
      write_reg(CFG_IDX_W'(REG_MAX_CODE) + CFG_IDX_W'($urandom_range(1, 3)),
                CFG_DATA_W'($urandom()));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic restart_stream();
    stream_frame = $urandom();
    zero_refs    = $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0)
      drift = int'($urandom_range(0, 30)) - 15;
    else
      drift = int'($urandom_range(0, 8)) - 4;
    if ($urandom_range(0, 3) == 0)
      ref_offset = $urandom();
    else
      ref_offset = $urandom_range(0, 50) * BLOCK_PERIOD_US_DEF + $urandom_range(0, 60) - 30;
  endtask

  task automatic send_stream_item();
    logic [TIME_W-1:0] frame;
    logic [TIME_W-1:0] ref_us;
    if ($urandom_range(0, 399) == 0) restart_stream();
    if ($urandom_range(0, 99) < 6) begin
      frame  = $urandom();
      ref_us = ($urandom_range(0, 3) == 0) ? '0 : TIME_W'($urandom());
    end else begin
      stream_frame += BLOCK_PERIOD_US_DEF;
      ref_offset   += drift;
      if ($urandom_range(0, 3) == 0) ref_offset += $urandom_range(0, 4) - 2;
      frame = stream_frame;
      if (zero_refs > 0) begin
        ref_us = '0;
        zero_refs--;
      end else begin
        ref_us = stream_frame + ref_offset;
      end
    end
    send_request(frame, ref_us);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (results_due == 0);
  endtask

  initial begin : result_sink
    int waits;
    int taken;
    bit eager;
    bit pressed;
    out_ready = 1'b0;
    taken     = 0;
    eager     = 1'b0;
    pressed   = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (!pressed && taken >= 300 && in_valid) begin
        waits   = PRESSURE_CYCLES;
        pressed = 1'b1;
      end else begin
        waits = eager ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (waits > 0) begin
        out_ready <= 1'b0;
        repeat (waits) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
      if (taken % 50 == 0) eager = ($urandom_range(0, 2) == 0);
    end
  end

  initial begin : stimulus
    int            sent;
    int            phase;
    int            n;
    trim_setting_t which;
    rst            = 1'b1;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    in_valid       = 1'b0;
    frame_start_us = '0;
    last_ref_us    = '0;
    sender_eager   = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    load_trim_setting(SET_DEFAULT);
    for (int i = 0; i < PROBE_COUNT; i++)
      send_request(PROBE_FRAME[i], PROBE_REF[i]);

    restart_stream();
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      if (phase > 0) begin
        if (phase <= SET_RANDOM)
          which = trim_setting_t'(phase);
        else if ($urandom_range(0, 1) == 0)
          which = SET_DEFAULT;
        else
          which = trim_setting_t'($urandom_range(0, SET_RANDOM));
        drain_results();
        load_trim_setting(which);
      end
      n            = $urandom_range(60, 140);
      sender_eager = ($urandom_range(0, 3) == 0);
      repeat (n) send_stream_item();
      sent += n;
      phase++;
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("audio_clock_drift_compensator_unit: match");
    else
      $display("audio_clock_drift_compensator_unit: mismatch");
    $finish;
  end

endmodule
